FILE: hw/rtl/ddsd_pkg.sv
// ----------------------------------------------------------------------------
// Decimal digit sorter package
// Shared constants, state types and the queue status bundle used by the
// converter front end, the hand-off queue and the sorting back end.
// ----------------------------------------------------------------------------
package ddsd_pkg;

  // Fixed field widths of the external beats.
  localparam int NUMBER_W = 64;
  localparam int DIGIT_W  = 4;

  // Defaults for the top level parameters.
  localparam int DEF_INPUT_BITS = 64;
  localparam int DEF_MAX_DIGITS = 20;

  // Binary bits folded into the BCD accumulator per cycle.
  localparam int STEP_BITS = 4;

  // Number of converted numbers that can wait between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] DAB_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DAB_ADJ   = 4'd3;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ZERO,
    B_RUN
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hw/rtl/ddsd_front.sv
// ----------------------------------------------------------------------------
// Decimal digit sorter front end
// Accepts a number and converts it to packed BCD with a shift-and-add-3
// accumulator, several bits per cycle, then hands digits and count to the
// queue.
// ----------------------------------------------------------------------------
module ddsd_front #(
  parameter int INPUT_BITS = ddsd_pkg::DEF_INPUT_BITS,
  parameter int MAX_DIGITS = ddsd_pkg::DEF_MAX_DIGITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [ddsd_pkg::NUMBER_W-1:0]              number,
  input  logic                                       push,
  output logic                                       full,
  input  ddsd_pkg::q_status_t                        q_status,
  output logic                                       q_push,
  output logic [ddsd_pkg::DIGIT_W*MAX_DIGITS-1:0]    q_digits,
  output logic [$clog2(MAX_DIGITS+1)-1:0]            q_count
);
  import ddsd_pkg::*;

  localparam int NSTEPS = (INPUT_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int SR_W   = NSTEPS * STEP_BITS;
  localparam int BCD_W  = DIGIT_W * MAX_DIGITS;
  localparam int STEP_W = $clog2(NSTEPS + 1);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

  front_state_t        state, state_next;
  logic [SR_W-1:0]     sreg;
  logic [BCD_W-1:0]    bcd;
  logic                ovf;
  logic [STEP_W-1:0]   step;

  logic [BCD_W-1:0]    bcd_work;
  logic                ovf_work;
  logic [CNT_W-1:0]    cnt_calc;

  // Fold STEP_BITS input bits into the BCD word. Carries out of the top
  // digit are dropped, which keeps only the low MAX_DIGITS digits; ovf
  // records that the number had more digits than that.
  always_comb begin
    bcd_work = bcd;
    ovf_work = ovf;
    for (int b = 0; b < STEP_BITS; b++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd_work[d*DIGIT_W +: DIGIT_W] >= DAB_LIMIT) begin
          bcd_work[d*DIGIT_W +: DIGIT_W] = bcd_work[d*DIGIT_W +: DIGIT_W] + DAB_ADJ;
        end
      end
      ovf_work = ovf_work | bcd_work[BCD_W-1];
      bcd_work = {bcd_work[BCD_W-2:0], sreg[SR_W-1-b]};
    end
  end

  // Digit count is the position of the highest nonzero digit, or MAX_DIGITS when ovf is set.
  always_comb begin
    cnt_calc = '0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        cnt_calc = CNT_W'(d + 1);
      end
    end
    if (ovf) begin
      cnt_calc = CNT_W'(MAX_DIGITS);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (push) state_next = F_CONV;
      end
      F_CONV: begin
        if (step == STEP_W'(NSTEPS - 1)) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_status.full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    case (state)
      F_IDLE: begin
        full = 1'b0;
      end
      F_CONV: begin
        full = 1'b1;
      end
      F_PUSH: begin
        q_push = !q_status.full;
      end
      default: begin
        full   = 1'b1;
        q_push = 1'b0;
      end
    endcase
  end

  assign q_digits = bcd;
  assign q_count  = cnt_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      sreg <= SR_W'(number[INPUT_BITS-1:0]);
      bcd  <= '0;
      ovf  <= 1'b0;
      step <= '0;
    end else if (state == F_CONV) begin
      sreg <= sreg << STEP_BITS;
      bcd  <= bcd_work;
      ovf  <= ovf_work;
      step <= step + STEP_W'(1);
    end
  end

endmodule

FILE: hw/rtl/ddsd_queue.sv
// ----------------------------------------------------------------------------
// Decimal digit sorter hand-off queue
// Small register FIFO that decouples the converter from the sorter.
// ----------------------------------------------------------------------------
module ddsd_queue #(
  parameter int WIDTH = ddsd_pkg::DEF_MAX_DIGITS * ddsd_pkg::DIGIT_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output ddsd_pkg::q_status_t status
);
  import ddsd_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [FILL_W-1:0] fill;
  logic              do_push, do_pop;

  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign status.full  = (fill == FILL_W'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign rdata        = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (do_pop) begin
        rp <= (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/ddsd_back.sv
// ----------------------------------------------------------------------------
// Decimal digit sorter back end
// Takes a converted number from the queue and emits its digits from nine
// down to zero, one beat per digit, through an output register.
// ----------------------------------------------------------------------------
module ddsd_back #(
  parameter int MAX_DIGITS = ddsd_pkg::DEF_MAX_DIGITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ddsd_pkg::q_status_t                     q_status,
  input  logic [ddsd_pkg::DIGIT_W*MAX_DIGITS-1:0] q_digits,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]         q_count,
  output logic                                    q_pop,
  output logic [ddsd_pkg::DIGIT_W-1:0]            digit,
  output logic                                    last,
  output logic                                    empty_res,
  output logic                                    empty,
  input  logic                                    pop
);
  import ddsd_pkg::*;

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  back_state_t          state, state_next;
  logic [BCD_W-1:0]     digits;
  logic [MAX_DIGITS-1:0] rem;
  logic [DIGIT_W-1:0]   val;
  logic                 ovalid;
  logic [DIGIT_W-1:0]   odigit;
  logic                 olast;
  logic                 oempty;

  logic [MAX_DIGITS-1:0] match, lowbit, rem_after, rem_load;
  logic                  any, fin, out_free, emit;

  // Remaining digits equal to the value being emitted; take the lowest one.
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      match[d]    = rem[d] && (digits[d*DIGIT_W +: DIGIT_W] == val);
      rem_load[d] = (CNT_W'(d) < q_count);
    end
  end

  assign lowbit    = match & (~match + MAX_DIGITS'(1));
  assign any       = |match;
  assign rem_after = rem & ~lowbit;
  assign fin       = (rem_after == '0);
  assign out_free  = !ovalid || pop;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_status.empty) state_next = (q_count == '0) ? B_ZERO : B_RUN;
      end
      B_ZERO: begin
        if (out_free) state_next = B_IDLE;
      end
      B_RUN: begin
        if (any && out_free && fin) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop = !q_status.empty;
      end
      B_ZERO: begin
        emit = out_free;
      end
      B_RUN: begin
        emit = any && out_free;
      end
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  assign digit     = odigit;
  assign last      = olast;
  assign empty_res = oempty;
  assign empty     = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      digits <= q_digits;
      rem    <= rem_load;
      val    <= DIGIT_MAX;
    end else if (state == B_RUN) begin
      if (any) begin
        if (out_free) rem <= rem_after;
      end else begin
        val <= val - DIGIT_W'(1);
      end
    end
    if (emit) begin
      odigit <= (state == B_ZERO) ? '0 : val;
      olast  <= (state == B_ZERO) ? 1'b1 : fin;
      oempty <= (state == B_ZERO);
    end
  end

  a_run_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (rem != '0))
    else $error("sorter running with no digits left");

  a_value_descends: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN && $past(state == B_RUN)) |-> (val <= $past(val)))
    else $error("scan value rose during a run");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (odigit <= DIGIT_MAX))
    else $error("output digit above nine");

  a_zero_beat: assert property (@(posedge clk) disable iff (rst)
    (ovalid && oempty) |-> (olast && odigit == '0))
    else $error("zero-input beat is not a lone zero digit");

endmodule

FILE: hw/rtl/decimal_digit_sort_descending_top.sv
// ----------------------------------------------------------------------------
// Decimal digit sorter, top level
// Splits an unsigned number into decimal digits and returns them largest
// first, one beat per digit, with the final beat of each number marked.
//
//   Channel   Handshake        Payload
//   --------  ---------------  --------------------------------------------
//   input     push / full      number[63:0] (low INPUT_BITS bits used)
//   result    pop / empty      digit[3:0], last, empty_res
//
// The front end accepts a number, folds four bits per cycle into a BCD
// accumulator and then hands the result off. The back end loads a number
// and emits its digits, stepping its scan value down from nine and passing
// over each value with no matching digit on the way; a zero number gives
// a single beat.
// A two-entry queue between them lets conversion of the next number overlap
// emission of the previous one. Reset is synchronous and needs no clearing
// pass. A stalled result side only holds the back end; the front end keeps
// converting until the queue fills, and then full stays high.
// ----------------------------------------------------------------------------
module decimal_digit_sort_descending_top #(
  parameter int INPUT_BITS = ddsd_pkg::DEF_INPUT_BITS,
  parameter int MAX_DIGITS = ddsd_pkg::DEF_MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ddsd_pkg::NUMBER_W-1:0] number,
  input  logic                          push,
  output logic                          full,
  output logic [ddsd_pkg::DIGIT_W-1:0]  digit,
  output logic                          last,
  output logic                          empty_res,
  output logic                          empty,
  input  logic                          pop
);
  import ddsd_pkg::*;

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int Q_W   = BCD_W + CNT_W;

  // Queue entry: count in the top bits, packed BCD digits below.
  q_status_t         q_status;
  logic              q_push, q_pop;
  logic [BCD_W-1:0]  f_digits, b_digits;
  logic [CNT_W-1:0]  f_count, b_count;
  logic [Q_W-1:0]    q_rdata;

  ddsd_front #(
    .INPUT_BITS (INPUT_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .number   (number),
    .push     (push),
    .full     (full),
    .q_status (q_status),
    .q_push   (q_push),
    .q_digits (f_digits),
    .q_count  (f_count)
  );

  ddsd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  ({f_count, f_digits}),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  assign b_digits = q_rdata[BCD_W-1:0];
  assign b_count  = q_rdata[Q_W-1:BCD_W];

  ddsd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_digits  (b_digits),
    .q_count   (b_count),
    .q_pop     (q_pop),
    .digit     (digit),
    .last      (last),
    .empty_res (empty_res),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

FILE: sim/decimal_digit_sort_descending_top_tb.sv
// ----------------------------------------------------------------------------
// Decimal digit sorter testbench
// Pushes 64-bit numbers into the sorter and checks every result beat against
// a model of the expected output. For each number the model works out the
// decimal digits, largest first, with the final beat marked. Both queue sides
// idle at random, and the result side at one point holds off long enough for
// the block to fill up and raise full.
// ----------------------------------------------------------------------------
module decimal_digit_sort_descending_top_tb;

  localparam int INPUT_BITS = ddsd_pkg::DEF_INPUT_BITS;
  localparam int MAX_DIGITS = ddsd_pkg::DEF_MAX_DIGITS;

  // Number of random numbers after the directed part.
  localparam int RANDOM_NUMBERS = 180;
  // The result side stops popping once for this many cycles, after it has
  // seen this many beats, so that the block backs up into its input.
  localparam int HOLD_AFTER_BEATS = 600;
  localparam int HOLD_CYCLES      = 400;
  // Cycles without any accepted beat before the run is declared hung. The
  // long hold above is the slowest stretch a correct block can show.
  localparam int HANG_LIMIT = 4000;
  // Quiet cycles after the last expected beat, to catch stray results.
  localparam int TAIL_CYCLES = 80;

  // --------------------------------------------------------------------------
  // Expected-digit store and checker
  // --------------------------------------------------------------------------
  class digit_scoreboard;
    typedef struct packed {
      logic [ddsd_pkg::DIGIT_W-1:0] digit;
      logic                         last;
      logic                         empty_res;
    } digit_beat_t;

    digit_beat_t expected_digits[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    // One line per problem, and a running count that decides the verdict.
    task report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Split an accepted number into its decimal digits and queue the beats
    // it must produce, largest digit first.
    task note_number(input logic [ddsd_pkg::NUMBER_W-1:0] value);
      logic [ddsd_pkg::NUMBER_W-1:0] rest;
      logic [ddsd_pkg::NUMBER_W-1:0] mask;
      int                            tally[10];
      int                            ndigits;
      int                            emitted;
      digit_beat_t                   beat;
      mask = (ddsd_pkg::DEF_INPUT_BITS >= 64) ? '1 :
             ((64'd1 << ddsd_pkg::DEF_INPUT_BITS) - 64'd1);
      rest = value & mask;
      ndigits = 0;
      emitted = 0;
      foreach (tally[i]) tally[i] = 0;
      // Extraction stops at the store depth; higher digits are dropped.
      while (rest != 0 && ndigits < ddsd_pkg::DEF_MAX_DIGITS) begin
        tally[rest % 10]++;
        rest = rest / 10;
        ndigits++;
      end
      if (ndigits == 0) begin
        // A zero number still yields one beat, flagged as having no digits.
        beat.digit     = '0;
        beat.last      = 1'b1;
        beat.empty_res = 1'b1;
        expected_digits.push_back(beat);
      end else begin
        for (int v = 9; v >= 0; v--) begin
          for (int k = 0; k < tally[v]; k++) begin
            emitted++;
            beat.digit     = 4'(v);
            beat.last      = (emitted == ndigits);
            beat.empty_res = 1'b0;
            expected_digits.push_back(beat);
          end
        end
      end
    endtask

    task check_beat(input logic [ddsd_pkg::DIGIT_W-1:0] digit, input logic last,
                    input logic empty_res);
      digit_beat_t want;
      if (expected_digits.size() == 0) begin
        report($sformatf("unexpected beat digit=%0d last=%0b empty_res=%0b",
                         digit, last, empty_res));
      end else begin
        want = expected_digits.pop_front();
        if (digit !== want.digit)
          report($sformatf("digit %0d, expected %0d", digit, want.digit));
        if (last !== want.last)
          report($sformatf("last %0b, expected %0b (digit %0d)", last, want.last,
                           want.digit));
        if (empty_res !== want.empty_res)
          report($sformatf("empty_res %0b, expected %0b", empty_res, want.empty_res));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block and its signals. Every input holds a known value from time zero.
  // --------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic [ddsd_pkg::NUMBER_W-1:0] number = '0;
  logic                          push = 1'b0;
  logic                          full;
  logic [ddsd_pkg::DIGIT_W-1:0]  digit;
  logic                          last;
  logic                          empty_res;
  logic                          empty;
  logic                          pop = 1'b0;

  digit_scoreboard sb = new();
  int              beats_seen = 0;

  decimal_digit_sort_descending_top #(
    .INPUT_BITS(INPUT_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .number   (number),
    .push     (push),
    .full     (full),
    .digit    (digit),
    .last     (last),
    .empty_res(empty_res),
    .empty    (empty),
    .pop      (pop)
  );

  always #5 clk = ~clk;

  // Idle lengths shared by both sides: mostly none, often a few cycles, and
  // now and then a long stretch so that gaps land on every phase of the
  // conversion and of the digit emission.
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Random numbers are shaped so that digit counts from one to twenty all
  // come up often, with many repeated digits, rather than only the
  // nineteen- and twenty-digit values a flat 64-bit draw would give.
  function automatic logic [63:0] pick_number();
    logic [63:0] value;
    int          len;
    int          lo_digit;
    int          hi_digit;
    int          kind;
    kind = $urandom_range(0, 9);
    value = '0;
    case (kind)
      0: value = '0;
      1, 2: value = {$urandom, $urandom};
      3, 4: value = 64'($urandom_range(0, 999));
      9: begin
        // Twenty digits: ten to the nineteenth up to the largest value.
        value = {$urandom, $urandom} % 64'd8446744073709551616;
        value = value + 64'd10000000000000000000;
      end
      default: begin
        // Up to nineteen digits drawn from a narrow band, so that runs of
        // equal digits are common.
        len = $urandom_range(1, 19);
        lo_digit = $urandom_range(0, 9);
        hi_digit = $urandom_range(lo_digit, 9);
        for (int i = 0; i < len; i++)
          value = value * 10 + 64'($urandom_range(lo_digit, hi_digit));
      end
    endcase
    return value;
  endfunction

  // Offer one number and hold it until the block takes it. Push is only
  // lowered when a gap follows, so back-to-back numbers keep it high.
  task automatic send_number(input logic [63:0] value, input int gap);
    number <= value;
    push   <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_number(value);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the block drain: every queued expectation has to come back.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side. Beats are sampled at the clock edge, before the block updates
  // its outputs, and pop for the next cycle is chosen right after.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int  run_left;
    int  stall_left;
    bit  held;
    run_left = 0;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_beat(digit, last, empty_res);
        beats_seen++;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (!held && beats_seen >= HOLD_AFTER_BEATS) begin
        // The one long hold: the sender keeps offering numbers meanwhile,
        // so the internal queue fills and full has to stall the input.
        held = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        run_left = 0;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        pop <= 1'b1;
      end else begin
        stall_left = pick_idle();
        run_left = $urandom_range(1, 25);
        if (stall_left > 0) begin
          stall_left--;
          pop <= 1'b0;
        end else begin
          run_left--;
          pop <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Hang detection: any cycle with a beat accepted on either side counts as
  // progress. Too long without one ends the run as a failure.
  // --------------------------------------------------------------------------
  initial begin : hang_watch
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("block hung: no beat accepted for %0d cycles", HANG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : input_side
    logic [63:0] directed_numbers[$];
    int          gap;
    directed_numbers = '{
      64'd0,                         // zero: one beat with the empty flag
      64'd1,
      64'd9,
      64'd10,                        // a zero digit sorts behind the one
      64'd100,
      64'd907,
      64'd1111,                      // all digits equal
      64'd9876543210,                // already in descending order
      64'd1234567890,                // ascending order, every digit value
      64'd5050505,
      64'd99,
      64'd42,
      64'd10000000000000000000,      // smallest twenty-digit value
      64'd18446744073709551615,      // largest value, all bits set
      64'd9999999999999999999,       // nineteen nines
      64'd12345678901234567890,
      64'h8000000000000000,          // top bit alone
      64'h5555555555555555,
      64'hAAAAAAAAAAAAAAAA,
      64'd0                          // zero again, after a long run
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_numbers[i]) send_number(directed_numbers[i], pick_idle());
    push <= 1'b0;
    // The sender pauses here until every expected beat has come back.
    wait_drained();
    @(posedge clk);

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      // A window of back-to-back numbers keeps the input side busy without
      // gaps for a while.
      gap = (i >= 40 && i < 70) ? 0 : pick_idle();
      send_number(pick_number(), gap);
      if (i == RANDOM_NUMBERS / 2) begin
        push <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
    end
    push <= 1'b0;

    // Everything queued must arrive, and nothing more may follow it.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.pending()));

    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
